// File: rtl/fir67_pkg.sv
// Shared widths, types and the Q1.15 tap coefficient table of the 67-tap FIR filter.
package fir67_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 8;
    localparam int COEF_COUNT = 67;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

    localparam t_coef TAP_COEF [COEF_COUNT] = '{
         -16'sd510,   -16'sd560,   -16'sd589,   -16'sd591,   -16'sd566,
         -16'sd510,   -16'sd423,   -16'sd308,   -16'sd167,     -16'sd5,
          16'sd172,    16'sd355,    16'sd537,    16'sd708,    16'sd861,
          16'sd987,   16'sd1078,   16'sd1129,   16'sd1135,   16'sd1094,
         16'sd1006,    16'sd872,    16'sd698,    16'sd489,    16'sd254,
            16'sd2,   -16'sd256,   -16'sd508,   -16'sd745,   -16'sd955,
        -16'sd1130,  -16'sd1260,  -16'sd1341,  16'sd31400,  -16'sd1341,
        -16'sd1260,  -16'sd1130,   -16'sd955,   -16'sd745,   -16'sd508,
         -16'sd256,      16'sd2,    16'sd254,    16'sd489,    16'sd698,
          16'sd872,   16'sd1006,   16'sd1094,   16'sd1135,   16'sd1129,
         16'sd1078,    16'sd987,    16'sd861,    16'sd708,    16'sd537,
          16'sd355,    16'sd172,     -16'sd5,   -16'sd167,   -16'sd308,
         -16'sd423,   -16'sd510,   -16'sd566,   -16'sd591,   -16'sd589,
         -16'sd560,   -16'sd510
    };

    function automatic t_coef coef_at(input logic [COEF_IDX_W-1:0] idx);
        t_coef c;
        c = '0;
        if (idx < COEF_IDX_W'(COEF_COUNT)) begin
            c = TAP_COEF[idx[6:0]];
        end
        return c;
    endfunction

endpackage

// File: rtl/fir67_in_if.sv
// Input sample channel: valid/ready handshake carrying one sample a beat.
interface fir67_in_if;
    logic                valid;
    logic                ready;
    fir67_pkg::t_sample  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// File: rtl/fir67_out_if.sv
// Output sample channel: valid/ready handshake carrying one filtered sample a beat.
interface fir67_out_if;
    logic                valid;
    logic                ready;
    fir67_pkg::t_sample  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/fir67_cell.sv
// One delay-chain cell: holds a sample and takes its neighbour's value when enabled.
module fir67_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fir67_pkg::t_sample i_d,
    output fir67_pkg::t_sample o_q
);

    fir67_pkg::t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/fir67_mac.sv
// Shared multiply-accumulate with truncation toward zero and 16-bit saturation.
module fir67_mac #(
    parameter int ACC_W     = 40,
    parameter int FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  fir67_pkg::t_mac_ctrl i_ctrl,
    input  fir67_pkg::t_sample   i_sample,
    input  fir67_pkg::t_coef     i_coef,
    output fir67_pkg::t_sample   o_y
);

    localparam int PROD_W = fir67_pkg::SAMPLE_W + fir67_pkg::COEF_W;
    localparam logic signed [ACC_W-1:0] BIAS    = {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_biased;
    logic signed [ACC_W-1:0]  w_scaled;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else begin
            if (i_ctrl.mul_en) begin
                r_prod <= i_sample * i_coef;
            end
            if (i_ctrl.acc_en) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // negative sums get a bias so the arithmetic shift rounds toward zero
    assign w_biased = r_acc[ACC_W-1] ? (r_acc + BIAS) : r_acc;
    assign w_scaled = w_biased >>> FRAC_BITS;

    always_comb begin
        priority if (w_scaled > SAT_MAX) begin
            o_y = 16'sh7fff;
        end else if (w_scaled < SAT_MIN) begin
            o_y = 16'sh8000;
        end else begin
            o_y = w_scaled[fir67_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// File: rtl/fir_filter_67_tap_top.sv
// Top level of the 67-tap symmetric FIR filter for signed 16-bit audio.
// Each accepted sample is shifted into a chain of TAP_COUNT delay cells, then the
// chain rotates once around while a single shared multiplier reads its tail cell
// against the matching Q1.15 coefficient. Each product is registered and then
// added to the accumulator, a drain state adds the last product, and the done
// state moves the truncated, saturated sum to the output register once that register
// is free. No new sample is taken while one is in flight. The next sample is taken
// as soon as the result is moved to the output register, even while that result is
// still waiting to be taken. The delay line reads as zeros after reset.
module fir_filter_67_tap_top #(
    parameter int TAP_COUNT      = 67,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fir67_in_if.sink     i_in,
    fir67_out_if.source  o_out
);

    localparam int STEP_W = $clog2(TAP_COUNT);
    localparam int ACC_W  = fir67_pkg::SAMPLE_W + fir67_pkg::COEF_W + STEP_W + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     n_step;
    logic                  r_out_vld;
    logic                  n_out_vld;
    fir67_pkg::t_sample    r_out_data;

    fir67_pkg::t_sample    w_tap [TAP_COUNT];
    fir67_pkg::t_sample    w_head;
    fir67_pkg::t_sample    w_y;
    fir67_pkg::t_coef      w_coef;
    fir67_pkg::t_mac_ctrl  w_mac_ctrl;
    logic                  w_accept;
    logic                  w_shift_en;
    logic                  w_out_free;

    assign i_in.ready   = (r_state == S_IDLE) && i_rst_n;
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_shift_en   = w_accept || (r_state == S_RUN);
    assign w_head       = (r_state == S_RUN) ? w_tap[TAP_COUNT-1] : i_in.sample_in;
    assign w_out_free   = !r_out_vld || o_out.ready;
    assign w_coef       = fir67_pkg::coef_at(fir67_pkg::COEF_IDX_W'(r_step));

    assign w_mac_ctrl.clr    = w_accept;
    assign w_mac_ctrl.mul_en = (r_state == S_RUN);
    assign w_mac_ctrl.acc_en = (r_state == S_RUN) || (r_state == S_DRAIN);

    for (genvar k = 0; k < TAP_COUNT; k++) begin : g_chain
        fir67_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_shift_en),
            .i_d     ((k == 0) ? w_head : w_tap[(k == 0) ? 0 : k-1]),
            .o_q     (w_tap[k])
        );
    end

    fir67_mac #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_mac_ctrl),
        .i_sample (w_tap[TAP_COUNT-1]),
        .i_coef   (w_coef),
        .o_y      (w_y)
    );

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_out_vld = r_out_vld && !o_out.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_step  = STEP_W'(TAP_COUNT - 1);
                end
            end
            S_RUN: begin
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_data <= w_y;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.sample_out = r_out_data;

endmodule

// File: rtl/fir67_checker.sv
// Port-level checks on the FIR filter top, bound to every instance.
module fir67_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input fir67_pkg::t_sample i_out_data
);

    logic w_in_beat;

    assign w_in_beat = i_in_valid && i_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !i_in_ready)
        else $error("input taken while a sample is in flight");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !$rose(i_out_valid))
        else $error("result appeared straight after input beat");

endmodule

bind fir_filter_67_tap_top fir67_checker u_fir67_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sample_out)
);
